/* rtl/core/cpid_pkg.sv */
package cpid_pkg;

    // default sizes, handed to the top level parameters
    localparam int DATA_WIDTH_DEF     = 16;
    localparam int ACC_WIDTH_DEF      = 32;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // gains are fixed 16 bit signed fixed point
    localparam int GAIN_WIDTH = 16;

    // configuration register map
    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS  = 6;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_OUTER_P = 3'd0;
    localparam t_cfg_idx CFG_OUTER_I = 3'd1;
    localparam t_cfg_idx CFG_OUTER_D = 3'd2;
    localparam t_cfg_idx CFG_INNER_P = 3'd3;
    localparam t_cfg_idx CFG_INNER_I = 3'd4;
    localparam t_cfg_idx CFG_INNER_D = 3'd5;
    localparam t_cfg_idx CFG_COUNT   = 3'd6;

    // inner proportional gain resets to 1.0 in Q8.8
    localparam logic signed [GAIN_WIDTH-1:0] INNER_P_RESET = 16'sd256;

    // datapath operation of one microcode step
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_ERR,
        OP_MUL_P,
        OP_MUL_I,
        OP_MUL_D,
        OP_ADD,
        OP_OUT
    } t_op;

    // sequencing of one microcode step
    typedef enum logic [1:0] {
        JC_NEXT,
        JC_WAIT_IN,
        JC_WAIT_OUT,
        JC_RESTART
    } t_jump;

    localparam logic LOOP_OUTER = 1'b0;
    localparam logic LOOP_INNER = 1'b1;

    typedef struct packed {
        t_op  op;
        logic loop;
    } t_ctrl;

    typedef struct packed {
        t_ctrl ctrl;
        t_jump jump;
    } t_ucode;

    localparam int STEP_W     = 4;
    localparam int PROG_DEPTH = 16;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_FIRST = 4'd0;

    // control store: wait for a request, run the outer loop, then the inner loop
    localparam t_ucode UCODE_ROM [PROG_DEPTH] = '{
        '{'{OP_IDLE,  LOOP_OUTER}, JC_WAIT_IN},
        '{'{OP_ERR,   LOOP_OUTER}, JC_NEXT},
        '{'{OP_MUL_P, LOOP_OUTER}, JC_NEXT},
        '{'{OP_MUL_I, LOOP_OUTER}, JC_NEXT},
        '{'{OP_MUL_D, LOOP_OUTER}, JC_NEXT},
        '{'{OP_ADD,   LOOP_OUTER}, JC_NEXT},
        '{'{OP_OUT,   LOOP_OUTER}, JC_NEXT},
        '{'{OP_ERR,   LOOP_INNER}, JC_NEXT},
        '{'{OP_MUL_P, LOOP_INNER}, JC_NEXT},
        '{'{OP_MUL_I, LOOP_INNER}, JC_NEXT},
        '{'{OP_MUL_D, LOOP_INNER}, JC_NEXT},
        '{'{OP_ADD,   LOOP_INNER}, JC_NEXT},
        '{'{OP_OUT,   LOOP_INNER}, JC_WAIT_OUT},
        '{'{OP_IDLE,  LOOP_OUTER}, JC_RESTART},
        '{'{OP_IDLE,  LOOP_OUTER}, JC_RESTART},
        '{'{OP_IDLE,  LOOP_OUTER}, JC_RESTART}
    };

endpackage

/* rtl/core/cpid_datapath.sv */
module cpid_datapath #(
    parameter int DATA_WIDTH     = cpid_pkg::DATA_WIDTH_DEF,
    parameter int ACC_WIDTH      = cpid_pkg::ACC_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = cpid_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  cpid_pkg::t_ctrl                          i_ctrl,
    input  logic signed [cpid_pkg::GAIN_WIDTH-1:0]   i_gain,
    input  logic signed [DATA_WIDTH-1:0]             i_meas,
    input  logic signed [DATA_WIDTH-1:0]             i_target,
    output logic signed [DATA_WIDTH-1:0]             o_drive
);

    localparam int GW  = cpid_pkg::GAIN_WIDTH;
    localparam int EW0 = DATA_WIDTH + 1;
    localparam int DRW = DATA_WIDTH + 2;
    localparam int OPW = (ACC_WIDTH > DRW) ? ACC_WIDTH : DRW;
    localparam int XW  = OPW + 1;
    localparam int PW  = GW + OPW;
    localparam int SW  = PW + 3;

    localparam logic signed [XW-1:0] ACC_MAX  = XW'({1'b0, {(ACC_WIDTH-1){1'b1}}});
    localparam logic signed [XW-1:0] ACC_MIN  = ~ACC_MAX;
    localparam logic signed [SW-1:0] DRV_MAX  = SW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam logic signed [SW-1:0] DRV_MIN  = ~DRV_MAX;
    localparam logic signed [SW-1:0] ROUND    = (SW'(1) << GAIN_FRAC_BITS) >> 1;

    logic signed [ACC_WIDTH-1:0] r_accum [2];
    logic signed [EW0-1:0]       r_prev  [2];
    logic signed [EW0-1:0]       r_err;
    logic signed [DRW-1:0]       r_der;
    logic signed [PW-1:0]        r_prod;
    logic signed [SW-1:0]        r_sum;

    logic signed [EW0-1:0]       w_err;
    logic signed [EW0-1:0]       w_prev;
    logic signed [DRW-1:0]       w_der;
    logic signed [XW-1:0]        w_acc_sum;
    logic signed [ACC_WIDTH-1:0] w_acc_sat;
    logic signed [OPW-1:0]       w_opnd;
    logic signed [PW-1:0]        w_prod;
    logic signed [SW-1:0]        w_rounded;
    logic signed [SW-1:0]        w_shifted;

    // error, derivative and saturating integral of the selected loop
    always_comb begin
        w_err  = EW0'(i_meas) - EW0'(i_target);
        w_prev = r_prev[i_ctrl.loop];
        if (w_prev == '0) begin
            w_der = '0;
        end else begin
            w_der = DRW'(w_err) - DRW'(w_prev);
        end
        w_acc_sum = XW'(r_accum[i_ctrl.loop]) + XW'(w_err);
        if (w_acc_sum > ACC_MAX) begin
            w_acc_sat = ACC_WIDTH'(ACC_MAX);
        end else if (w_acc_sum < ACC_MIN) begin
            w_acc_sat = ACC_WIDTH'(ACC_MIN);
        end else begin
            w_acc_sat = ACC_WIDTH'(w_acc_sum);
        end
    end

    // shared multiplier operand
    always_comb begin
        unique case (i_ctrl.op)
            cpid_pkg::OP_MUL_P: w_opnd = OPW'(r_err);
            cpid_pkg::OP_MUL_I: w_opnd = OPW'(r_accum[i_ctrl.loop]);
            cpid_pkg::OP_MUL_D: w_opnd = OPW'(r_der);
            default:            w_opnd = '0;
        endcase
        w_prod = PW'(i_gain) * PW'(w_opnd);
    end

    // round, scale and saturate
    always_comb begin
        w_rounded = r_sum + ROUND;
        w_shifted = w_rounded >>> GAIN_FRAC_BITS;
        if (w_shifted > DRV_MAX) begin
            o_drive = DATA_WIDTH'(DRV_MAX);
        end else if (w_shifted < DRV_MIN) begin
            o_drive = DATA_WIDTH'(DRV_MIN);
        end else begin
            o_drive = DATA_WIDTH'(w_shifted);
        end
    end

    // loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum[0] <= '0;
            r_accum[1] <= '0;
            r_prev[0]  <= '0;
            r_prev[1]  <= '0;
        end else if (i_ctrl.op == cpid_pkg::OP_ERR) begin
            r_accum[i_ctrl.loop] <= w_acc_sat;
            r_prev[i_ctrl.loop]  <= w_err;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            cpid_pkg::OP_ERR: begin
                r_err <= w_err;
                r_der <= w_der;
                r_sum <= '0;
            end
            cpid_pkg::OP_MUL_P: begin
                r_prod <= w_prod;
            end
            cpid_pkg::OP_MUL_I, cpid_pkg::OP_MUL_D: begin
                r_sum  <= r_sum + SW'(r_prod);
                r_prod <= w_prod;
            end
            cpid_pkg::OP_ADD: begin
                r_sum <= r_sum + SW'(r_prod);
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/core/cascaded_pid_two_loop.sv */
// cascaded two-loop pid controller, one control tick per request
// input channel (i_in_valid / o_in_ready) carries outer measured, outer target
//   and inner measured; the outer loop runs first and its drive is the inner
//   loop's target
// output channel (o_out_valid / i_out_ready) carries both saturated drives
// config channel (i_cfg_valid / o_cfg_ready) writes the six signed gains by
//   index; o_cfg_ready is high whenever reset is released, writes to unused
//   indexes are dropped, and gains should only change while no request is in flight
// a request runs through the whole control store before the next one is taken;
//   a single shared multiplier forms the six gain products one after another
//   under the control store
// the input side is free again as soon as the result is loaded, so the next
//   request is taken while the previous result still waits for the receiver
// a stalled receiver holds the sequencer in its last step until the output
//   register frees up
// reset (synchronous, active low) clears the integrals and previous errors,
//   sets all gains to zero except the inner proportional gain, which is 1.0;
//   both ready outputs stay low while reset is held
module cascaded_pid_two_loop #(
    parameter int DATA_WIDTH     = cpid_pkg::DATA_WIDTH_DEF,
    parameter int ACC_WIDTH      = cpid_pkg::ACC_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = cpid_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input requests
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [DATA_WIDTH-1:0]           i_outer_measured,
    input  logic signed [DATA_WIDTH-1:0]           i_outer_target,
    input  logic signed [DATA_WIDTH-1:0]           i_inner_measured,
    // results
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [DATA_WIDTH-1:0]           o_outer_drive,
    output logic signed [DATA_WIDTH-1:0]           o_inner_drive,
    // gain writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [cpid_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic signed [cpid_pkg::GAIN_WIDTH-1:0] i_cfg_data
);

    localparam int GW = cpid_pkg::GAIN_WIDTH;

    // sequencer
    cpid_pkg::t_step  r_step;
    cpid_pkg::t_step  n_step;
    cpid_pkg::t_ucode w_uc;
    logic             w_accept;
    logic             w_finish;

    // gain registers
    logic signed [GW-1:0] r_gain [cpid_pkg::NUM_REGS];
    logic signed [GW-1:0] w_gain;

    // captured request and intermediate outer drive
    logic signed [DATA_WIDTH-1:0] r_in_om;
    logic signed [DATA_WIDTH-1:0] r_in_ot;
    logic signed [DATA_WIDTH-1:0] r_in_im;
    logic signed [DATA_WIDTH-1:0] r_outer_drive;

    // datapath hookup
    logic signed [DATA_WIDTH-1:0] w_meas;
    logic signed [DATA_WIDTH-1:0] w_target;
    logic signed [DATA_WIDTH-1:0] w_drive;

    // output register
    logic                         r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_out_outer;
    logic signed [DATA_WIDTH-1:0] r_out_inner;

    // fetch the control word of the current step
    assign w_uc = cpid_pkg::UCODE_ROM[r_step];

    // a request is only taken in the wait step at the top of the program
    assign o_in_ready = i_rst_n && (w_uc.jump == cpid_pkg::JC_WAIT_IN);
    assign w_accept   = i_in_valid && o_in_ready;

    // last step completes once the output register can take the result
    assign w_finish = (w_uc.jump == cpid_pkg::JC_WAIT_OUT) &&
                      (!r_out_valid || i_out_ready);

    // next step: fall through, wait on a condition, or jump back to the top
    always_comb begin
        unique case (w_uc.jump)
            cpid_pkg::JC_NEXT: begin
                n_step = r_step + cpid_pkg::t_step'(1);
            end
            cpid_pkg::JC_WAIT_IN: begin
                n_step = w_accept ? r_step + cpid_pkg::t_step'(1) : r_step;
            end
            cpid_pkg::JC_WAIT_OUT: begin
                n_step = w_finish ? cpid_pkg::STEP_FIRST : r_step;
            end
            default: begin
                n_step = cpid_pkg::STEP_FIRST;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= cpid_pkg::STEP_FIRST;
        end else begin
            r_step <= n_step;
        end
    end

    // gain writes; ready outside reset, unknown indexes are ignored
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cpid_pkg::NUM_REGS; k++) begin
                r_gain[k] <= (k == int'(cpid_pkg::CFG_INNER_P)) ?
                             cpid_pkg::INNER_P_RESET : '0;
            end
        end else if (i_cfg_valid && (i_cfg_index < cpid_pkg::CFG_COUNT)) begin
            r_gain[i_cfg_index] <= i_cfg_data;
        end
    end

    // gain for the current multiply step
    always_comb begin
        unique case (w_uc.ctrl.op)
            cpid_pkg::OP_MUL_P: begin
                w_gain = (w_uc.ctrl.loop == cpid_pkg::LOOP_INNER) ?
                         r_gain[cpid_pkg::CFG_INNER_P] : r_gain[cpid_pkg::CFG_OUTER_P];
            end
            cpid_pkg::OP_MUL_I: begin
                w_gain = (w_uc.ctrl.loop == cpid_pkg::LOOP_INNER) ?
                         r_gain[cpid_pkg::CFG_INNER_I] : r_gain[cpid_pkg::CFG_OUTER_I];
            end
            cpid_pkg::OP_MUL_D: begin
                w_gain = (w_uc.ctrl.loop == cpid_pkg::LOOP_INNER) ?
                         r_gain[cpid_pkg::CFG_INNER_D] : r_gain[cpid_pkg::CFG_OUTER_D];
            end
            default: begin
                w_gain = '0;
            end
        endcase
    end

    // capture the request when it is taken
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_om <= i_outer_measured;
            r_in_ot <= i_outer_target;
            r_in_im <= i_inner_measured;
        end
    end

    // inner loop chases the outer drive
    assign w_meas   = (w_uc.ctrl.loop == cpid_pkg::LOOP_INNER) ? r_in_im : r_in_om;
    assign w_target = (w_uc.ctrl.loop == cpid_pkg::LOOP_INNER) ? r_outer_drive : r_in_ot;

    cpid_datapath #(
        .DATA_WIDTH     (DATA_WIDTH),
        .ACC_WIDTH      (ACC_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_uc.ctrl),
        .i_gain   (w_gain),
        .i_meas   (w_meas),
        .i_target (w_target),
        .o_drive  (w_drive)
    );

    // hold the outer drive for the inner loop and for the result
    always_ff @(posedge i_clk) begin
        if ((w_uc.ctrl.op == cpid_pkg::OP_OUT) &&
            (w_uc.ctrl.loop == cpid_pkg::LOOP_OUTER)) begin
            r_outer_drive <= w_drive;
        end
    end

    // output register, loaded at the end of the program
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_outer <= r_outer_drive;
            r_out_inner <= w_drive;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_outer_drive = r_out_outer;
    assign o_inner_drive = r_out_inner;

endmodule

/* bench/cascaded_pid_two_loop_tb.sv */
module cascaded_pid_two_loop_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = cpid_pkg::DATA_WIDTH_DEF;
    localparam int AW = cpid_pkg::ACC_WIDTH_DEF;
    localparam int FB = cpid_pkg::GAIN_FRAC_BITS_DEF;

    // cycles in which no channel moves anything before the run is given up
    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_TICKS = 110;
    // enough to push both drives onto their rails through the integrals alone
    localparam int WINDUP_TICKS = 70;
    localparam int SETTLE_CYCLES = 30;

    typedef logic signed [DW-1:0]                  t_sample;
    typedef logic signed [cpid_pkg::GAIN_WIDTH-1:0] t_gain;

    typedef struct packed {
        t_sample outer_drive;
        t_sample inner_drive;
    } t_drive_pair;

    // flavors of gain sets used by the random phases
    typedef enum {GS_SMALL, GS_MID, GS_FULL, GS_MAX, GS_MIN} t_gain_set;

    localparam t_sample SAMPLE_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam t_gain   GAIN_MAX   = {1'b0, {(cpid_pkg::GAIN_WIDTH-1){1'b1}}};
    localparam t_gain   GAIN_MIN   = {1'b1, {(cpid_pkg::GAIN_WIDTH-1){1'b0}}};
    localparam t_gain   GAIN_ONE   = cpid_pkg::INNER_P_RESET;
    // highest index the port can carry, never a real register
    localparam cpid_pkg::t_cfg_idx CFG_TOP_UNUSED = '1;

    // tracks gains and loop state, predicts both drives of every control tick
    class cascade_checker;
        t_gain       gain [cpid_pkg::NUM_REGS];
        longint      outer_accum;
        longint      outer_prev;
        longint      inner_accum;
        longint      inner_prev;
        t_drive_pair pending_drives [$];
        int          fails;

        function new();
            foreach (gain[k]) gain[k] = '0;
            gain[cpid_pkg::CFG_INNER_P] = cpid_pkg::INNER_P_RESET;
            outer_accum = 0;
            outer_prev  = 0;
            inner_accum = 0;
            inner_prev  = 0;
            fails       = 0;
        endfunction

        function void write_gain(cpid_pkg::t_cfg_idx idx, t_gain data);
            // writes to indexes past the map are dropped
            if (idx < cpid_pkg::CFG_COUNT) gain[idx] = data;
        endfunction

        // one pid loop: saturating integral, derivative off when last error was zero
        function t_sample pid_loop(input longint meas, input longint target,
                                   input longint kp, input longint ki, input longint kd,
                                   inout longint accum, inout longint prev);
            longint acc_max;
            longint drv_max;
            longint err;
            longint der;
            longint sum;
            longint half;
            acc_max = (longint'(1) <<< (AW - 1)) - 1;
            drv_max = (longint'(1) <<< (DW - 1)) - 1;
            half    = (longint'(1) <<< FB) >>> 1;
            err = meas - target;
            der = (prev == 0) ? 0 : err - prev;
            accum = accum + err;
            if (accum > acc_max) accum = acc_max;
            else if (accum < -acc_max - 1) accum = -acc_max - 1;
            sum = kp * err + ki * accum + kd * der;
            // round half up, then drop the fraction bits
            sum = (sum + half) >>> FB;
            prev = err;
            if (sum > drv_max) sum = drv_max;
            else if (sum < -drv_max - 1) sum = -drv_max - 1;
            return t_sample'(sum);
        endfunction

        function void note_tick(t_sample om, t_sample ot, t_sample im);
            t_drive_pair d;
            t_sample     od;
            t_sample     id;
            od = pid_loop(om, ot, gain[cpid_pkg::CFG_OUTER_P], gain[cpid_pkg::CFG_OUTER_I],
                          gain[cpid_pkg::CFG_OUTER_D], outer_accum, outer_prev);
            // the outer drive is the inner target
            id = pid_loop(im, od, gain[cpid_pkg::CFG_INNER_P], gain[cpid_pkg::CFG_INNER_I],
                          gain[cpid_pkg::CFG_INNER_D], inner_accum, inner_prev);
            d.outer_drive = od;
            d.inner_drive = id;
            pending_drives.push_back(d);
        endfunction

        function void check_drives(t_sample od, t_sample id);
            t_drive_pair d;
            t_sample     exp_od;
            t_sample     exp_id;
            if (pending_drives.size() == 0) begin
                $error("result with no request pending: outer_drive %0d inner_drive %0d",
                       od, id);
                fails++;
                return;
            end
            d = pending_drives.pop_front();
            exp_od = d.outer_drive;
            exp_id = d.inner_drive;
            if (od !== exp_od) begin
                $error("outer_drive expected %0d actual %0d", exp_od, od);
                fails++;
            end
            if (id !== exp_id) begin
                $error("inner_drive expected %0d actual %0d", exp_id, id);
                fails++;
            end
        endfunction
    endclass

    // every input known from time zero
    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_in_valid       = 1'b0;
    t_sample             i_outer_measured = '0;
    t_sample             i_outer_target   = '0;
    t_sample             i_inner_measured = '0;
    logic                i_out_ready      = 1'b0;
    logic                i_cfg_valid      = 1'b0;
    cpid_pkg::t_cfg_idx  i_cfg_index      = cpid_pkg::CFG_OUTER_P;
    t_gain               i_cfg_data       = '0;

    logic     o_in_ready;
    logic     o_out_valid;
    t_sample  o_outer_drive;
    t_sample  o_inner_drive;
    logic     o_cfg_ready;

    cascade_checker checker_h = new();

    // idle chances in percent, per cycle
    int send_idle = 31;
    int recv_idle = 54;
    int quiet_cycles = 0;

    cascaded_pid_two_loop u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_outer_measured (i_outer_measured),
        .i_outer_target   (i_outer_target),
        .i_inner_measured (i_inner_measured),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_outer_drive    (o_outer_drive),
        .o_inner_drive    (o_inner_drive),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver: drops ready at random, at the rate of the current phase
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // handshake monitor: all three channels sampled at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) checker_h.write_gain(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                checker_h.note_tick(i_outer_measured, i_outer_target, i_inner_measured);
            if (o_out_valid && i_out_ready)
                checker_h.check_drives(o_outer_drive, o_inner_drive);
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // one control tick; called at an edge, returns at the edge that takes it
    task automatic send_tick(t_sample om, t_sample ot, t_sample im);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_outer_measured <= om;
        i_outer_target   <= ot;
        i_inner_measured <= im;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic drain_ticks();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (checker_h.pending_drives.size() != 0);
    endtask

    task automatic write_reg(cpid_pkg::t_cfg_idx idx, t_gain data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // full gain set, with junk to the unused indexes mixed in; block must be idle
    task automatic load_gains(t_gain outer_p, t_gain outer_i, t_gain outer_d,
                              t_gain inner_p, t_gain inner_i, t_gain inner_d);
        write_reg(cpid_pkg::CFG_COUNT, t_gain'($urandom));
        write_reg(cpid_pkg::CFG_OUTER_P, outer_p);
        write_reg(cpid_pkg::CFG_OUTER_I, outer_i);
        write_reg(cpid_pkg::CFG_OUTER_D, outer_d);
        write_reg(CFG_TOP_UNUSED, t_gain'($urandom));
        write_reg(cpid_pkg::CFG_INNER_P, inner_p);
        write_reg(cpid_pkg::CFG_INNER_I, inner_i);
        write_reg(cpid_pkg::CFG_INNER_D, inner_d);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_gain rand_gain(t_gain_set kind);
        case (kind)
            GS_SMALL: return t_gain'(int'($urandom_range(1024)) - 512);
            GS_MID:   return t_gain'(int'($urandom_range(8192)) - 4096);
            GS_FULL:  return t_gain'($urandom);
            GS_MAX:   return GAIN_MAX;
            default:  return GAIN_MIN;
        endcase
    endfunction

    // mix of full range, rail values and small values near zero
    function automatic t_sample rand_sample();
        case ($urandom_range(3))
            0: return t_sample'($urandom);
            1: begin
                case ($urandom_range(4))
                    0:       return SAMPLE_MIN;
                    1:       return SAMPLE_MAX;
                    2:       return t_sample'(-1);
                    3:       return t_sample'(1);
                    default: return '0;
                endcase
            end
            default: return t_sample'(int'($urandom_range(64)) - 32);
        endcase
    endfunction

    task automatic run_random(t_gain_set kind, int s_idle, int r_idle);
        t_sample om;
        t_sample ot;
        t_sample im;
        load_gains(rand_gain(kind), rand_gain(kind), rand_gain(kind),
                   rand_gain(kind), rand_gain(kind), rand_gain(kind));
        send_idle = s_idle;
        recv_idle = r_idle;
        repeat (RANDOM_TICKS) begin
            om = rand_sample();
            // now and then a zero outer error, so the next derivative is skipped
            ot = ($urandom_range(7) == 0) ? om : rand_sample();
            im = rand_sample();
            send_tick(om, ot, im);
        end
        drain_ticks();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset gains: outer drive is zero, inner drive follows inner measured
        // first tick has no previous error, so no derivative
        send_tick(0, 0, 0);
        send_tick(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        send_tick(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
        drain_ticks();

        // mixed-sign moderate gains
        load_gains(16'sd384, 16'sd32, -16'sd64, 16'sd200, -16'sd16, 16'sd512);
        send_tick(100, 100, 0);              // zero outer error
        send_tick(150, 100, 5);              // derivative skipped after it
        send_tick(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
        send_tick(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        send_tick(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN);   // drives run into the rails
        send_tick(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX);
        send_tick(0, 1, 0);
        send_tick(1, 0, 1);
        send_tick(-1, 0, -1);
        drain_ticks();

        // outer loop off, so the outer drive is zero and inner error is inner measured
        load_gains(0, 0, 0, GAIN_MIN, GAIN_MAX, GAIN_MIN);
        send_tick(5, -7, 0);                 // zero inner error
        send_tick(3, 3, 12);                 // inner derivative skipped
        send_tick(0, 0, SAMPLE_MAX);
        send_tick(0, 0, SAMPLE_MIN);
        send_tick(0, 0, 1);
        drain_ticks();

        // random phases: sender light and receiver heavy idling, then swapped, then none
        run_random(GS_SMALL, 31, 54);
        run_random(GS_MAX, 31, 54);
        run_random(GS_MIN, 54, 31);
        run_random(GS_FULL, 54, 31);
        run_random(GS_MID, 0, 0);
        run_random(GS_SMALL, 0, 0);

        // integral build-up: outer error pinned negative, outer drive pinned low, so
        // the inner error is pinned high; only the integral terms are live and both
        // drives sit on their rails once the integrals have grown
        load_gains(0, GAIN_MAX, 0, 0, GAIN_MIN, 0);
        repeat (WINDUP_TICKS) send_tick(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX);
        drain_ticks();

        // a stray late result would show up here
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (checker_h.fails == 0 && checker_h.pending_drives.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
